// ----- src/lkvc_pkg.sv -----
// Package for the LRU key-value cache: sizes, transaction payload types,
// the stored entry layout and the sequencer states. No dependencies.
package lkvc_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = IDX_W + 1;
    localparam int VALUE_W  = 16;
    localparam int STAMP_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 32;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [63:0]         key;
        logic [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [VALUE_W-1:0]  read_value;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  hits_so_far;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [VALUE_W-1:0]  value;
        logic [STAMP_W-1:0]  stamp;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

// ----- src/lru_key_value_cache.sv -----
// Fully associative key-value cache with least-recently-used replacement.
// Entries live in one synchronous memory that is scanned one entry a cycle.
// Depends on lkvc_pkg.
//
// Channel  Signals                     Direction  Payload
// req      req_valid, req_stall, req   in         lkvc_pkg::req_t
// rsp      rsp_valid, rsp_stall, rsp   out        lkvc_pkg::rsp_t
//
// Each transaction passes through an accept step, then a scan with one memory read per
// entry through the single read port, each entry compared once its registered read
// data returns, then a write step that writes the entry back on an insert or a hit and loads the result.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
// A result that is stalled holds the block in its write step until it is taken.
module lru_key_value_cache (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  lkvc_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lkvc_pkg::rsp_t  rsp
);

    lkvc_pkg::entry_t                   mem [lkvc_pkg::ENTRIES];

    lkvc_pkg::state_t                   state_reg, state_next;
    logic [lkvc_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                               cmp_valid_reg, cmp_valid_next;
    logic [lkvc_pkg::IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                               found_reg, found_next;
    logic [lkvc_pkg::STAMP_W-1:0]       clock_reg, clock_next;
    logic [lkvc_pkg::COUNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [lkvc_pkg::ENTRIES-1:0]       entry_valid_reg, entry_valid_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    logic                               rd_live_reg;

    lkvc_pkg::req_t                     req_reg, req_next;
    logic [lkvc_pkg::IDX_W-1:0]         match_idx_reg, match_idx_next;
    logic [lkvc_pkg::VALUE_W-1:0]       match_value_reg, match_value_next;
    logic [lkvc_pkg::STAMP_W-1:0]       min_stamp_reg, min_stamp_next;
    logic [lkvc_pkg::IDX_W-1:0]         victim_reg, victim_next;
    lkvc_pkg::rsp_t                     rsp_reg, rsp_next;
    lkvc_pkg::entry_t                   rd_data_reg;

    lkvc_pkg::entry_t                   rd_entry;
    lkvc_pkg::entry_t                   wr_entry;
    logic                               mem_rd_en;
    logic                               mem_we;
    logic [lkvc_pkg::IDX_W-1:0]         rd_addr;
    logic [lkvc_pkg::IDX_W-1:0]         wr_addr;
    logic [lkvc_pkg::STAMP_W-1:0]       clock_inc;
    logic                               rsp_free;

    assign req_stall = (state_reg != lkvc_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rd_entry  = rd_live_reg ? rd_data_reg : '0;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign clock_inc = (clock_reg == lkvc_pkg::STAMP_MAX) ? clock_reg : clock_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lkvc_pkg::ST_IDLE;
            cnt_reg         <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
            found_reg       <= 1'b0;
            clock_reg       <= '0;
            hit_cnt_reg     <= '0;
            entry_valid_reg <= '0;
            rsp_valid_reg   <= 1'b0;
            rd_live_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_idx_reg     <= cmp_idx_next;
            found_reg       <= found_next;
            clock_reg       <= clock_next;
            hit_cnt_reg     <= hit_cnt_next;
            entry_valid_reg <= entry_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (mem_rd_en)
            begin
                rd_live_reg <= entry_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        match_idx_reg   <= match_idx_next;
        match_value_reg <= match_value_next;
        min_stamp_reg   <= min_stamp_next;
        victim_reg      <= victim_next;
        rsp_reg         <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        clock_next       = clock_reg;
        hit_cnt_next     = hit_cnt_reg;
        entry_valid_next = entry_valid_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        req_next         = req_reg;
        match_idx_next   = match_idx_reg;
        match_value_next = match_value_reg;
        min_stamp_next   = min_stamp_reg;
        victim_next      = victim_reg;
        rsp_next         = rsp_reg;
        mem_rd_en        = 1'b0;
        mem_we           = 1'b0;
        rd_addr          = cnt_reg[lkvc_pkg::IDX_W-1:0];
        wr_addr          = victim_reg;
        wr_entry.key     = req_reg.key[lkvc_pkg::KEY_BITS-1:0];
        wr_entry.value   = req_reg.value;
        wr_entry.stamp   = clock_reg;

        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                if (cnt_reg < lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES))
                begin
                    mem_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = cnt_reg[lkvc_pkg::IDX_W-1:0];
                    cnt_next       = cnt_reg + 1'b1;
                end
                if (cmp_valid_reg)
                begin
                    if (req_reg.opcode == lkvc_pkg::OP_LOOKUP)
                    begin
                        if (!found_reg &&
                            rd_entry.key == req_reg.key[lkvc_pkg::KEY_BITS-1:0])
                        begin
                            found_next       = 1'b1;
                            match_idx_next   = cmp_idx_reg;
                            match_value_next = rd_entry.value;
                        end
                    end
                    else
                    begin
                        if (cmp_idx_reg == '0 || rd_entry.stamp < min_stamp_reg)
                        begin
                            min_stamp_next = rd_entry.stamp;
                            victim_next    = cmp_idx_reg;
                        end
                    end
                    if (cmp_idx_reg == lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1))
                    begin
                        state_next = lkvc_pkg::ST_WRITE;
                    end
                end
            end
            lkvc_pkg::ST_WRITE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = lkvc_pkg::ST_IDLE;
                    rsp_next       = '0;
                    if (req_reg.opcode == lkvc_pkg::OP_INSERT)
                    begin
                        mem_we                    = 1'b1;
                        wr_addr                   = victim_reg;
                        entry_valid_next[wr_addr] = 1'b1;
                        clock_next                = clock_inc;
                        rsp_next.slot             = lkvc_pkg::SLOT_W'(victim_reg);
                        rsp_next.hits_so_far      = hit_cnt_reg;
                    end
                    else if (found_reg)
                    begin
                        mem_we                    = 1'b1;
                        wr_addr                   = match_idx_reg;
                        wr_entry.value            = match_value_reg;
                        entry_valid_next[wr_addr] = 1'b1;
                        clock_next                = clock_inc;
                        hit_cnt_next              = (hit_cnt_reg == lkvc_pkg::COUNT_MAX) ?
                                                    hit_cnt_reg : hit_cnt_reg + 1'b1;
                        rsp_next.hit              = 1'b1;
                        rsp_next.read_value       = match_value_reg;
                        rsp_next.slot             = lkvc_pkg::SLOT_W'(match_idx_reg);
                        rsp_next.hits_so_far      = hit_cnt_next;
                    end
                    else
                    begin
                        rsp_next.hits_so_far = hit_cnt_reg;
                    end
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == lkvc_pkg::ST_SCAN))
        else $error("Accepted transaction did not start a scan.");

    a_write_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvc_pkg::ST_WRITE && rsp_free) |=> rsp_valid)
        else $error("Write step did not present a result.");

    a_hit_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> (hit_cnt_reg >= $past(hit_cnt_reg)))
        else $error("Hit counter decreased.");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n |=> (clock_reg >= $past(clock_reg)))
        else $error("Use clock decreased.");

    a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.read_value == '0))
        else $error("Result without a hit carries a nonzero value.");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lru_key_value_cache: directed and random lookups and
// inserts, checked against an internal LRU store. Depends on lkvc_pkg and the RTL.
module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int POOL_DEPTH   = 24;
    localparam int RANDOM_ITEMS = 1930;
    localparam int HOLD_CYCLES  = 400;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    lkvc_pkg::req_t  req       = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    lkvc_pkg::rsp_t  rsp;

    logic [lkvc_pkg::KEY_BITS-1:0] shadow_key   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VALUE_W-1:0]  shadow_value [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::STAMP_W-1:0]  shadow_stamp [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::STAMP_W-1:0]  use_clock;
    logic [lkvc_pkg::COUNT_W-1:0]  hit_count;

    lkvc_pkg::req_t  pending_reqs[$];
    lkvc_pkg::rsp_t  expected_rsps[$];
    logic [63:0]     key_pool[$];

    int n_total;
    int n_accepted;
    int n_results;
    int n_hits;
    int n_misses;
    int n_inserts;
    int n_errors;
    int cycles;
    int hold_left;
    logic hold_done;

    lru_key_value_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want,
                 n_results);
        n_errors++;
    endtask

    function automatic logic [lkvc_pkg::STAMP_W-1:0] take_stamp();
        logic [lkvc_pkg::STAMP_W-1:0] now;
        now = use_clock;
        if (use_clock != lkvc_pkg::STAMP_MAX)
        begin
            use_clock++;
        end
        return now;
    endfunction

    // Applies one transaction to the shadow store and returns its result.
    function automatic lkvc_pkg::rsp_t cache_apply(lkvc_pkg::req_t r);
        lkvc_pkg::rsp_t                o;
        logic [lkvc_pkg::KEY_BITS-1:0] k;
        int                            victim;
        o = '0;
        k = r.key[lkvc_pkg::KEY_BITS-1:0];
        if (r.opcode == lkvc_pkg::OP_LOOKUP)
        begin
            for (int i = 0; i < lkvc_pkg::ENTRIES && !o.hit; i++)
            begin
                if (shadow_key[i] == k)
                begin
                    if (hit_count != lkvc_pkg::COUNT_MAX)
                    begin
                        hit_count++;
                    end
                    shadow_stamp[i] = take_stamp();
                    o.hit = 1'b1;
                    o.read_value = shadow_value[i];
                    o.slot = lkvc_pkg::SLOT_W'(i);
                end
            end
            if (o.hit)
            begin
                n_hits++;
            end
            else
            begin
                n_misses++;
            end
        end
        else
        begin
            victim = 0;
            for (int i = 1; i < lkvc_pkg::ENTRIES; i++)
            begin
                if (shadow_stamp[i] < shadow_stamp[victim])
                begin
                    victim = i;
                end
            end
            shadow_key[victim] = k;
            shadow_value[victim] = r.value;
            shadow_stamp[victim] = take_stamp();
            o.slot = lkvc_pkg::SLOT_W'(victim);
            n_inserts++;
        end
        o.hits_so_far = hit_count;
        return o;
    endfunction

    task automatic add_item(lkvc_pkg::opcode_t op, logic [63:0] k,
                            logic [lkvc_pkg::VALUE_W-1:0] v);
        lkvc_pkg::req_t r;
        r.opcode = op;
        r.key = k;
        r.value = v;
        pending_reqs.push_back(r);
        if (op == lkvc_pkg::OP_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > POOL_DEPTH)
            begin
                void'(key_pool.pop_front());
            end
        end
    endtask

    function automatic logic [63:0] random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            return 64'($urandom_range(15));
        end
        return {$urandom, $urandom};
    endfunction

    // Sender: offers queued transactions and updates the shadow store on acceptance.
    always @(posedge clk or negedge rst_n)
    begin : drive
        int idle_pct;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            n_accepted <= 0;
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                shadow_key[i] = '0;
                shadow_value[i] = '0;
                shadow_stamp[i] = '0;
            end
            use_clock = '0;
            hit_count = '0;
        end
        else
        begin
            idle_pct = (n_accepted < n_total / 3) ? 24 :
                       (n_accepted < 2 * n_total / 3) ? 50 : 0;
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(cache_apply(req));
                n_accepted <= n_accepted + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    always @(posedge clk or negedge rst_n)
    begin : receive
        int stall_pct;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            stall_pct = (n_accepted < n_total / 3) ? 50 :
                        (n_accepted < 2 * n_total / 3) ? 24 : 0;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && n_accepted >= n_total / 6)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : watch
        lkvc_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch("result with no transaction outstanding", 64'(rsp), '0);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.hit !== want.hit)
                begin
                    report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
                end
                if (rsp.read_value !== want.read_value)
                begin
                    report_mismatch("read_value", 64'(rsp.read_value), 64'(want.read_value));
                end
                if (rsp.slot !== want.slot)
                begin
                    report_mismatch("slot", 64'(rsp.slot), 64'(want.slot));
                end
                if (rsp.hits_so_far !== want.hits_so_far)
                begin
                    report_mismatch("hits_so_far", 64'(rsp.hits_so_far),
                                    64'(want.hits_so_far));
                end
            end
            n_results <= n_results + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                     expected_rsps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int pick;
        n_errors = 0;
        n_results = 0;
        cycles = 0;
        n_hits = 0;
        n_misses = 0;
        n_inserts = 0;

        // The cleared store holds zero keys, so a zero key hits entry 0.
        add_item(lkvc_pkg::OP_LOOKUP, 64'h0, 16'h0);
        add_item(lkvc_pkg::OP_LOOKUP, '1, 16'hFFFF);
        add_item(lkvc_pkg::OP_INSERT, '1, 16'hFFFF);
        add_item(lkvc_pkg::OP_LOOKUP, '1, 16'h0);
        add_item(lkvc_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 16'h0001);
        add_item(lkvc_pkg::OP_INSERT, 64'h0, 16'hA5A5);
        add_item(lkvc_pkg::OP_LOOKUP, 64'h0, 16'h0);
        add_item(lkvc_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 16'h5A5A);
        add_item(lkvc_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001, 16'hFFFF);
        add_item(lkvc_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 16'h0);
        for (int i = 1; i <= 12; i++)
        begin
            add_item(lkvc_pkg::OP_INSERT, {16{4'(i)}}, 16'(i * 16'h1357));
        end
        add_item(lkvc_pkg::OP_LOOKUP, '1, 16'h0);
        add_item(lkvc_pkg::OP_LOOKUP, {16{4'(12)}}, 16'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                add_item(lkvc_pkg::OP_INSERT, random_key(), 16'($urandom));
            end
            else if (pick < 48)
            begin
                add_item(lkvc_pkg::OP_INSERT, key_pool[$urandom_range(key_pool.size() - 1)],
                         16'($urandom));
            end
            else if (pick < 88)
            begin
                add_item(lkvc_pkg::OP_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)],
                         16'($urandom));
            end
            else if (pick < 94)
            begin
                add_item(lkvc_pkg::OP_LOOKUP, random_key(), 16'($urandom));
            end
            else
            begin
                add_item(lkvc_pkg::OP_LOOKUP, 64'h0, 16'($urandom));
            end
        end
        n_total = pending_reqs.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (n_results < n_total)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            report_mismatch("results never delivered", 64'(expected_rsps.size()), '0);
        end

        $display("Checked %0d results from %0d transactions in %0d cycles.", n_results,
                 n_accepted, cycles);
        $display("Lookups hit %0d and missed %0d; %0d inserts; %0d mismatches.", n_hits,
                 n_misses, n_inserts, n_errors);
        if (n_errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/lkvc_pkg.sv
src/lru_key_value_cache.sv
test/tb_top.sv
